[src/lcs_pkg.sv]
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the longest common subsequence block.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int SYM_W     = 8;   // string byte
    localparam int LEN_W     = 6;   // length field on the result item
    localparam int S_TDATA_W = 8;   // symbol
    localparam int S_TUSER_W = 2;   // func, no_symbol
    localparam int M_TDATA_W = 16;  // symbol_res, length, zero pad
    localparam int M_TUSER_W = 2;   // has_symbol, overflow

    // tuser bit positions
    localparam int S_USER_FUNC = 0;
    localparam int S_USER_NONE = 1;
    localparam int M_USER_HAS  = 0;
    localparam int M_USER_OVF  = 1;

    // func codes
    localparam logic FUNC_SOURCE = 1'b0;
    localparam logic FUNC_TARGET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_START,
        ST_FILL_RD,
        ST_FILL_CALC,
        ST_TB_START,
        ST_TB_LEN,
        ST_TB_RD_UP,
        ST_TB_RD_LF,
        ST_TB_STEP,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic match;   // source byte equals target byte
        logic up_gt;   // entry above strictly greater than entry to the left
    } cell_flags_t;

endpackage

[src/lcs_cell_unit.sv]
// ----------------------------------------------------------------------------
// lcs_cell_unit
// Shared table cell: byte compare, max of up/left, diagonal increment.
// ----------------------------------------------------------------------------
module lcs_cell_unit #(
    parameter int VW = 6
) (
    input  logic [lcs_pkg::SYM_W-1:0] sym_a,
    input  logic [lcs_pkg::SYM_W-1:0] sym_b,
    input  logic [VW-1:0]             diag,
    input  logic [VW-1:0]             up,
    input  logic [VW-1:0]             left,
    output lcs_pkg::cell_flags_t      flags,
    output logic [VW-1:0]             value
);
    import lcs_pkg::*;

    always_comb begin
        flags.match = (sym_a == sym_b);
        flags.up_gt = (up > left);
        if (flags.match) begin
            value = diag + VW'(1);
        end else if (flags.up_gt) begin
            value = up;
        end else begin
            value = left;
        end
    end

endmodule

[src/longest_common_subsequence.sv]
// ----------------------------------------------------------------------------
// longest_common_subsequence
// Loads a source and a target byte string and returns their longest common
// subsequence, one result item per byte, first byte first. s_tready is high
// while loading (s_tuser[0] = 0 source, 1 target; s_tuser[1] marks an item
// without a byte; s_tlast ends a string). Bytes beyond MAX_LEN per string
// are dropped and flagged as overflow. The last target item starts the work
// and s_tready stays low until the final result item has been taken. One
// shared cell unit and a two-port MAX_LEN*MAX_LEN entry length table set the
// pace: the fill has a setup state, then a read and a write state per entry;
// the traceback a start and a length read, then per step (at most T+S, T
// target and S source bytes) an up read, a left read and, without a match,
// a step state; each result item a read, a load and a wait held while
// m_tready is low. With an empty string fill and traceback end in their
// start states. An empty subsequence gives one item with has_symbol low and
// length zero. A source item after a closed source string starts a new run.
// ----------------------------------------------------------------------------
module longest_common_subsequence #(
    parameter int MAX_LEN = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcs_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] symbol
    input  logic                          s_tlast,   // last
    input  logic [lcs_pkg::S_TUSER_W-1:0] s_tuser,   // [0] func, [1] no_symbol
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lcs_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] symbol_res, [13:8] length, pad
    output logic                          m_tlast,   // last_res
    output logic [lcs_pkg::M_TUSER_W-1:0] m_tuser    // [0] has_symbol, [1] overflow
);
    import lcs_pkg::*;

    localparam int CW    = $clog2(MAX_LEN + 1);              // counts and table values
    localparam int IW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int DEPTH = MAX_LEN * MAX_LEN;
    localparam int TW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

    // Row-major table address: row = target index, column = source index.
    function automatic logic [TW-1:0] tbl_addr(input logic [IW-1:0] ri,
                                               input logic [IW-1:0] ci);
        tbl_addr = TW'(ri) * TW'(MAX_LEN) + TW'(ci);
    endfunction

    // ---------------------------------------------------------------- state
    state_t          state_reg, state_next;
    logic [CW-1:0]   src_cnt_reg, src_cnt_next;
    logic [CW-1:0]   tgt_cnt_reg, tgt_cnt_next;
    logic            trunc_reg, trunc_next;
    logic            closed_reg, closed_next;
    logic [CW-1:0]   r_reg, r_next;        // current row, 1-based
    logic [CW-1:0]   c_reg, c_next;        // current column, 1-based
    logic [CW-1:0]   diag_reg, diag_next;
    logic [CW-1:0]   left_reg, left_next;
    logic [CW-1:0]   up_reg, up_next;
    logic [CW-1:0]   len_reg, len_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   k_reg, k_next;        // result item index

    // Output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [SYM_W-1:0] m_sym_reg, m_sym_next;
    logic             m_has_reg, m_has_next;
    logic [LEN_W-1:0] m_len_reg, m_len_next;
    logic             m_ovf_reg, m_ovf_next;
    logic             m_last_reg, m_last_next;

    // ------------------------------------------------------------- memories
    logic [SYM_W-1:0] src_mem [MAX_LEN];
    logic [SYM_W-1:0] tgt_mem [MAX_LEN];
    logic [SYM_W-1:0] res_mem [MAX_LEN];
    logic [CW-1:0]    tbl_mem [DEPTH];

    logic             src_we, tgt_we, res_we, tbl_we;
    logic [IW-1:0]    src_waddr, tgt_waddr, res_waddr;
    logic [IW-1:0]    src_raddr, tgt_raddr, res_raddr;
    logic [TW-1:0]    tbl_waddr, tbl_raddr;
    logic [SYM_W-1:0] res_wdata;
    logic [CW-1:0]    tbl_wdata;
    logic [SYM_W-1:0] src_rd_reg, tgt_rd_reg, res_rd_reg;
    logic [CW-1:0]    tbl_rd_reg;

    // ----------------------------------------------------------- input side
    logic             in_acc;
    logic             in_func;
    logic             in_none;
    logic [SYM_W-1:0] in_sym;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_func  = s_tuser[S_USER_FUNC];
    assign in_none  = s_tuser[S_USER_NONE];
    assign in_sym   = s_tdata[SYM_W-1:0];

    // Index helpers
    logic [CW-1:0] rm1, rm2, cm1, cm2, pm1, tm1, sm1;
    assign rm1 = r_reg - ONE;
    assign rm2 = r_reg - TWO;
    assign cm1 = c_reg - ONE;
    assign cm2 = c_reg - TWO;
    assign pm1 = pos_reg - ONE;
    assign tm1 = tgt_cnt_reg - ONE;
    assign sm1 = src_cnt_reg - ONE;

    // Neighbor entries, zero on the table's border
    logic [CW-1:0] up_sel, left_sel;
    assign up_sel   = (r_reg > ONE) ? tbl_rd_reg : '0;
    assign left_sel = (c_reg > ONE) ? tbl_rd_reg : '0;

    // ---------------------------------------------------------- shared unit
    cell_flags_t   cell_flags;
    logic [CW-1:0] cell_up, cell_left, cell_value;

    // Traceback step compares the held up entry with the fresh left entry.
    assign cell_up   = (state_reg == ST_TB_STEP) ? up_reg   : up_sel;
    assign cell_left = (state_reg == ST_TB_STEP) ? left_sel : left_reg;

    lcs_cell_unit #(
        .VW (CW)
    ) u_cell (
        .sym_a (src_rd_reg),
        .sym_b (tgt_rd_reg),
        .diag  (diag_reg),
        .up    (cell_up),
        .left  (cell_left),
        .flags (cell_flags),
        .value (cell_value)
    );

    // ----------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && (in_func == FUNC_TARGET) && s_tlast) begin
                    state_next = ST_FILL_START;
                end
            end
            ST_FILL_START: begin
                if ((src_cnt_reg == '0) || (tgt_cnt_reg == '0)) begin
                    state_next = ST_TB_START;
                end else begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD: state_next = ST_FILL_CALC;
            ST_FILL_CALC: begin
                if ((c_reg == src_cnt_reg) && (r_reg == tgt_cnt_reg)) begin
                    state_next = ST_TB_START;
                end else begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_TB_START: begin
                if ((src_cnt_reg == '0) || (tgt_cnt_reg == '0)) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_TB_LEN;
                end
            end
            ST_TB_LEN: state_next = ST_TB_RD_UP;
            ST_TB_RD_UP: begin
                if ((r_reg == '0) || (c_reg == '0) || (pos_reg == '0)) begin
                    state_next = ST_OUT_RD;
                end else begin
                    state_next = ST_TB_RD_LF;
                end
            end
            ST_TB_RD_LF: begin
                if (cell_flags.match) begin
                    state_next = ST_TB_RD_UP;
                end else begin
                    state_next = ST_TB_STEP;
                end
            end
            ST_TB_STEP:  state_next = ST_TB_RD_UP;
            ST_OUT_RD:   state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = m_last_reg ? ST_IDLE : ST_OUT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------ datapath control
    always_comb begin
        logic [CW-1:0] cnt_eff;
        logic          trunc_eff;

        cnt_eff       = '0;
        trunc_eff     = trunc_reg;

        src_cnt_next  = src_cnt_reg;
        tgt_cnt_next  = tgt_cnt_reg;
        trunc_next    = trunc_reg;
        closed_next   = closed_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        diag_next     = diag_reg;
        left_next     = left_reg;
        up_next       = up_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;

        m_tvalid_next = m_tvalid_reg;
        m_sym_next    = m_sym_reg;
        m_has_next    = m_has_reg;
        m_len_next    = m_len_reg;
        m_ovf_next    = m_ovf_reg;
        m_last_next   = m_last_reg;

        src_we        = 1'b0;
        tgt_we        = 1'b0;
        res_we        = 1'b0;
        tbl_we        = 1'b0;
        src_waddr     = '0;
        tgt_waddr     = '0;
        res_waddr     = pm1[IW-1:0];
        res_wdata     = src_rd_reg;
        tbl_waddr     = tbl_addr(rm1[IW-1:0], cm1[IW-1:0]);
        tbl_wdata     = cell_value;
        src_raddr     = cm1[IW-1:0];
        tgt_raddr     = rm1[IW-1:0];
        tbl_raddr     = tbl_addr(rm2[IW-1:0], cm1[IW-1:0]);
        res_raddr     = k_reg[IW-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_func == FUNC_SOURCE) begin
                        // a source item after a closed source opens a new run
                        cnt_eff   = closed_reg ? '0 : src_cnt_reg;
                        trunc_eff = closed_reg ? 1'b0 : trunc_reg;
                        if (closed_reg) begin
                            tgt_cnt_next = '0;
                        end
                        src_cnt_next = cnt_eff;
                        if (!in_none) begin
                            if (cnt_eff < MAX_CNT) begin
                                src_we       = 1'b1;
                                src_waddr    = cnt_eff[IW-1:0];
                                src_cnt_next = cnt_eff + ONE;
                            end else begin
                                trunc_eff = 1'b1;
                            end
                        end
                        trunc_next  = trunc_eff;
                        closed_next = s_tlast;
                    end else begin
                        if (!in_none) begin
                            if (tgt_cnt_reg < MAX_CNT) begin
                                tgt_we       = 1'b1;
                                tgt_waddr    = tgt_cnt_reg[IW-1:0];
                                tgt_cnt_next = tgt_cnt_reg + ONE;
                            end else begin
                                trunc_next = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_FILL_START: begin
                r_next    = ONE;
                c_next    = ONE;
                diag_next = '0;
                left_next = '0;
            end
            ST_FILL_RD: begin
                // addresses at their defaults: source c-1, target r-1, up entry
            end
            ST_FILL_CALC: begin
                tbl_we = 1'b1;
                if (c_reg == src_cnt_reg) begin
                    c_next    = ONE;
                    left_next = '0;
                    diag_next = '0;
                    if (r_reg != tgt_cnt_reg) begin
                        r_next = r_reg + ONE;
                    end
                end else begin
                    c_next    = c_reg + ONE;
                    left_next = cell_value;
                    diag_next = up_sel;
                end
            end
            ST_TB_START: begin
                r_next    = tgt_cnt_reg;
                c_next    = src_cnt_reg;
                len_next  = '0;
                pos_next  = '0;
                k_next    = '0;
                tbl_raddr = tbl_addr(tm1[IW-1:0], sm1[IW-1:0]);
            end
            ST_TB_LEN: begin
                len_next = tbl_rd_reg;
                pos_next = tbl_rd_reg;
            end
            ST_TB_RD_UP: begin
                // reads at their defaults
            end
            ST_TB_RD_LF: begin
                up_next   = up_sel;
                tbl_raddr = tbl_addr(rm1[IW-1:0], cm2[IW-1:0]);
                if (cell_flags.match) begin
                    // results land back to front
                    res_we   = 1'b1;
                    pos_next = pm1;
                    r_next   = rm1;
                    c_next   = cm1;
                end
            end
            ST_TB_STEP: begin
                if (cell_flags.up_gt) begin
                    r_next = rm1;
                end else begin
                    c_next = cm1;
                end
            end
            ST_OUT_RD: begin
                // result byte read at k
            end
            ST_OUT_LOAD: begin
                m_tvalid_next = 1'b1;
                m_has_next    = (len_reg != '0);
                m_sym_next    = (len_reg != '0) ? res_rd_reg : '0;
                m_len_next    = LEN_W'(len_reg);
                m_ovf_next    = trunc_reg;
                m_last_next   = (len_reg == '0) || (k_reg == len_reg - ONE);
            end
            ST_OUT_WAIT: begin
                if (m_tready) begin
                    m_tvalid_next = 1'b0;
                    if (m_last_reg) begin
                        src_cnt_next = '0;
                        tgt_cnt_next = '0;
                        trunc_next   = 1'b0;
                        closed_next  = 1'b0;
                    end else begin
                        k_next = k_reg + ONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            src_cnt_reg  <= '0;
            tgt_cnt_reg  <= '0;
            trunc_reg    <= 1'b0;
            closed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            src_cnt_reg  <= src_cnt_next;
            tgt_cnt_reg  <= tgt_cnt_next;
            trunc_reg    <= trunc_next;
            closed_reg   <= closed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_reg      <= r_next;
        c_reg      <= c_next;
        diag_reg   <= diag_next;
        left_reg   <= left_next;
        up_reg     <= up_next;
        len_reg    <= len_next;
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        m_sym_reg  <= m_sym_next;
        m_has_reg  <= m_has_next;
        m_len_reg  <= m_len_next;
        m_ovf_reg  <= m_ovf_next;
        m_last_reg <= m_last_next;
    end

    // Memories: one write and one registered read each per cycle
    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[src_waddr] <= in_sym;
        end
        src_rd_reg <= src_mem[src_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tgt_we) begin
            tgt_mem[tgt_waddr] <= in_sym;
        end
        tgt_rd_reg <= tgt_mem[tgt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (res_we) begin
            res_mem[res_waddr] <= res_wdata;
        end
        res_rd_reg <= res_mem[res_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    // --------------------------------------------------------------- output
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - LEN_W - SYM_W){1'b0}}, m_len_reg, m_sym_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_has_reg};

endmodule

[src/lcs_checker.sv]
// ----------------------------------------------------------------------------
// lcs_checker
// Port-level checks for the longest common subsequence block.
// ----------------------------------------------------------------------------
module lcs_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lcs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tlast,
    input logic [lcs_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lcs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast,
    input logic [lcs_pkg::M_TUSER_W-1:0] m_tuser
);
    import lcs_pkg::*;

    // no new item while results of a run are pending
    a_busy_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result item waits");

    // the last target item starts the run; the block goes busy
    a_busy_after_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast && (s_tuser[S_USER_FUNC] == FUNC_TARGET))
        |=> !s_tready)
        else $error("still ready after the last target item");

    // an item without a byte is the single item of an empty result
    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[M_USER_HAS])
        |-> (m_tlast && (m_tdata[LEN_W+SYM_W-1:SYM_W] == '0)))
        else $error("empty result item malformed");

    // the final result item returns the block to loading
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not ready after the final result item");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready)
        |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result item changed while stalled");

endmodule

bind longest_common_subsequence lcs_checker u_lcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
